// ===== rtl/core/etrc_pkg.sv =====
// etrc_pkg: shared constants and control types for the edge trigger ring capture
// no dependencies; used by etrc_ctrl, etrc_datapath and edge_trigger_ring_capture
`default_nettype none

package etrc_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int SAMPLE_W      = 12;
   localparam int PRE_DIVISOR   = 10;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_ARM    = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic commit;       // store a sample, check trigger, advance write index
      logic commit_hold;  // commit data comes from the hold register
      logic arm_we;       // load arming state from the request
      logic hold_we;      // park the request sample while a dump runs
      logic dump_start;   // point the read side at the oldest entry, clear pending
      logic rd_en;        // read ring at the dump pointer
      logic out_load;     // move read data into the response register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic dump_due;     // capture pending and write index at end position
      logic rd_last;      // the word being loaded is the last of the dump
      logic out_free;     // response register can take a word this cycle
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/etrc_ctrl.sv =====
// etrc_ctrl: sequencer for item acceptance and ring dumps
// depends on etrc_pkg
`default_nettype none

module etrc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_op,
   output logic                  req_stall,
   input  wire etrc_pkg::sts_type sts,
   output etrc_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DUMP_RD,
      ST_DUMP_OUT,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   assign req_stall = stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == etrc_pkg::OP_ARM) begin
                  cmd.arm_we = 1'b1;
               end else if (sts.dump_due) begin
                  cmd.hold_we    = 1'b1;
                  cmd.dump_start = 1'b1;
                  state_in       = ST_DUMP_RD;
               end else begin
                  cmd.commit = 1'b1;
               end
            end
         end
         ST_DUMP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.rd_last) begin
                  state_in = ST_COMMIT;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         ST_COMMIT: begin
            cmd.commit      = 1'b1;
            cmd.commit_hold = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/etrc_datapath.sv =====
// etrc_datapath: sample ring, trigger detect, dump read path and response register
// depends on etrc_pkg
`default_nettype none

module etrc_datapath #(
   parameter int DEPTH = etrc_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire etrc_pkg::cmd_type             cmd,
   output etrc_pkg::sts_type                  sts,
   input  wire logic [etrc_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                          req_arm_state,
   input  wire logic                          csr_we,
   input  wire logic [etrc_pkg::SAMPLE_W-1:0] csr_wdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [etrc_pkg::SAMPLE_W-1:0]      rsp_dump_sample,
   output logic                               rsp_last_of_dump
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int BACK  = (DEPTH / etrc_pkg::PRE_DIVISOR) % DEPTH;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0] BACK_IDX = IDX_W'(BACK);

   logic [etrc_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];
   logic [DEPTH-1:0]              written_ff;

   logic [IDX_W-1:0]              wr_ff, end_ff, ptr_ff, cnt_ff;
   logic                          pending_ff, armed_ff;
   logic [etrc_pkg::SAMPLE_W-1:0] prev_ff, level_ff, hold_ff;
   logic [etrc_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                          rd_ok_ff;
   logic                          out_valid_ff, out_last_ff;
   logic [etrc_pkg::SAMPLE_W-1:0] out_data_ff;

   logic [etrc_pkg::SAMPLE_W-1:0] commit_data;
   logic                          rising, falling, fire;
   logic [IDX_W-1:0]              wr_in, end_in, rd_word, end_wrap;

   assign commit_data = cmd.commit_hold ? hold_ff : req_sample;
   assign rising  = (prev_ff < level_ff) && (commit_data >= level_ff);
   assign falling = (prev_ff > level_ff) && (commit_data <= level_ff);
   assign fire    = armed_ff && (rising || falling);

   assign wr_in    = (wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1;
   // pre-trigger history: end sits BACK slots before the trigger slot
   assign end_wrap = wr_ff + IDX_W'(DEPTH - BACK);
   assign end_in   = (wr_ff >= BACK_IDX) ? (wr_ff - BACK_IDX) : end_wrap;

   // dump word counter starts from zero
   assign rd_word = '0;

   assign sts.dump_due = pending_ff && (wr_ff == end_ff);
   assign sts.rd_last  = (cnt_ff == LAST_IDX);
   assign sts.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid        = out_valid_ff;
   assign rsp_dump_sample  = out_data_ff;
   assign rsp_last_of_dump = out_last_ff;

   // ring storage and its registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ring_mem[wr_ff] <= commit_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[ptr_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.hold_we) begin
         hold_ff <= req_sample;
      end
      if (cmd.out_load) begin
         out_data_ff <= rd_ok_ff ? rd_data_ff : {etrc_pkg::SAMPLE_W{1'b0}};
         out_last_ff <= sts.rd_last;
      end
      if (cmd.dump_start) begin
         ptr_ff <= wr_ff;
      end else if (cmd.rd_en) begin
         ptr_ff <= (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
      end
      if (cmd.dump_start) begin
         cnt_ff <= rd_word;
      end else if (cmd.out_load) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         wr_ff        <= '0;
         end_ff       <= '0;
         pending_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         prev_ff      <= '0;
         level_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            level_ff <= csr_wdata;
         end
         if (cmd.arm_we) begin
            armed_ff <= req_arm_state;
         end
         if (cmd.dump_start) begin
            pending_ff <= 1'b0;
         end
         if (cmd.commit) begin
            written_ff[wr_ff] <= 1'b1;
            prev_ff           <= commit_data;
            wr_ff             <= wr_in;
            if (fire) begin
               end_ff     <= end_in;
               pending_ff <= 1'b1;
               armed_ff   <= 1'b0;
            end
         end
         if (cmd.rd_en) begin
            rd_ok_ff <= written_ff[ptr_ff];
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/edge_trigger_ring_capture.sv =====
// edge_trigger_ring_capture: scope capture with edge trigger and pre-trigger history
// depends on etrc_pkg, etrc_ctrl and etrc_datapath
//
// usage
//   req channel: one word per handshake (req_valid high, req_stall low).
//     req_op selects a converter sample (req_sample) or an arming update
//     (req_arm_state). samples can stream at one per clock while no dump
//     is running.
//   csr port: csr_we writes csr_wdata as the trigger level; write only
//     while the block is idle.
//   rsp channel: dump words, oldest first, rsp_last_of_dump on the last.
//     a dump holds DEPTH words, all stored samples of the ring.
//   a dump is triggered by the first sample word that arrives once the
//     write position reaches the end position after a crossing. req_stall
//     then stays high until the held sample is stored, also while
//     rsp_stall is held; words pass the ring read register and the response
//     register, one word per cycle from the single ring read port unless stalled.
//   when the receiver stalls, the response register holds its word and
//     the dump sequencer waits; the triggering sample is stored after the
//     last dump word has been loaded.
//   reset clears the ring (per-entry written bits, unwritten slots read
//     as zero), indexes, arming, pending capture and the trigger level.
//   no clearing pass is needed after reset.
`default_nettype none

module edge_trigger_ring_capture #(
   parameter int DEPTH = etrc_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [etrc_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                          req_arm_state,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [etrc_pkg::SAMPLE_W-1:0]      rsp_dump_sample,
   output logic                               rsp_last_of_dump,
   // trigger level register
   input  wire logic                          csr_we,
   input  wire logic [etrc_pkg::SAMPLE_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   etrc_pkg::cmd_type cmd;
   etrc_pkg::sts_type sts;

   // sequencer: accepts words, runs the dump, then commits the held sample
   etrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // ring, trigger compare, end position and response register
   etrc_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_sample       (req_sample),
      .req_arm_state    (req_arm_state),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dump_sample  (rsp_dump_sample),
      .rsp_last_of_dump (rsp_last_of_dump)
   );

endmodule

`default_nettype wire
